// ===== design/tabulated_cooling_rate_unit_defines.svh =====
// ----------------------------------------------------------------------------
// tabulated_cooling_rate_unit_defines
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef TABULATED_COOLING_RATE_UNIT_DEFINES_SVH
`define TABULATED_COOLING_RATE_UNIT_DEFINES_SVH

// Property checked only while out of reset.
`define CTR_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked at every edge, reset included.
`define CTR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/ctr_pkg.sv =====
// ----------------------------------------------------------------------------
// ctr_pkg
// Types and constants shared by the tabulated cooling rate unit.
// ----------------------------------------------------------------------------
`default_nettype none
package ctr_pkg;

    // command field codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    // item kinds decided by the front part
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_EVAL  = 2'd1;
    localparam logic [1:0] KIND_ZDENS = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BELOW = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_ZDENS = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_TFAC   = 3'd0;
    localparam logic [2:0] CFG_TMIN   = 3'd1;
    localparam logic [2:0] CFG_PFLOOR = 3'd2;
    localparam logic [2:0] CFG_RSCALE = 3'd3;
    localparam logic [2:0] CFG_ECOUNT = 3'd4;

    // divider geometry: 65 bit dividend, 32 bit divisor
    localparam int DIV_NW = 65;
    localparam int DIV_CW = 7;

    typedef struct packed {
        logic [31:0] tfac;
        logic [31:0] tmin;
        logic [30:0] pfloor;
        logic [31:0] rscale;
        logic [12:0] ecount;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] idx;
        logic [31:0] etemp;
        logic [31:0] erate;
        logic [31:0] dens;
        logic [31:0] pres;
    } t_item;

endpackage
`default_nettype wire

// ===== design/ctr_ram.sv =====
// ----------------------------------------------------------------------------
// ctr_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module ctr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== design/ctr_front.sv =====
// ----------------------------------------------------------------------------
// ctr_front
// Accepts commands, classifies them and queues them for the back part.
// ----------------------------------------------------------------------------
`default_nettype none
module ctr_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic                i_command,
    input  wire logic [11:0]         i_entry_index,
    input  wire logic [31:0]         i_entry_temperature,
    input  wire logic [31:0]         i_entry_rate,
    input  wire logic [31:0]         i_density,
    input  wire logic signed [31:0]  i_pressure,
    input  wire logic [30:0]         i_pfloor,
    output ctr_pkg::t_item           o_head,
    output logic                     o_head_vld,
    input  wire logic                i_pop
);
    import ctr_pkg::*;

    t_item      w_item;
    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push;

    // classify the incoming command
    always_comb begin
        w_item.idx   = i_entry_index;
        w_item.etemp = i_entry_temperature;
        w_item.erate = i_entry_rate;
        w_item.dens  = i_density;
        // negative pressure is raised to the floor
        w_item.pres  = i_pressure[31] ? {1'b0, i_pfloor} : i_pressure;
        if (i_command == CMD_WRITE) begin
            w_item.kind = KIND_WRITE;
        end else if (i_density == 32'd0) begin
            w_item.kind = KIND_ZDENS;
        end else begin
            w_item.kind = KIND_EVAL;
        end
    end

    assign busy       = (r_cnt == 2'd2);
    assign w_push     = start && !busy;
    assign o_head     = r_q[r_rp];
    assign o_head_vld = (r_cnt != 2'd0);

    // two entry queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_pop);
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end
endmodule
`default_nettype wire

// ===== design/ctr_div.sv =====
// ----------------------------------------------------------------------------
// ctr_div
// Restoring divider, one quotient bit per cycle and one step per dividend bit;
// done strobe in the cycle after the last step.
// ----------------------------------------------------------------------------
`default_nettype none
module ctr_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [ctr_pkg::DIV_NW-1:0] i_dividend,
    input  wire logic [31:0]                i_divisor,
    output logic                            o_done,
    output logic [ctr_pkg::DIV_NW-1:0]      o_quotient
);
    import ctr_pkg::*;

    logic              r_busy;
    logic [DIV_CW-1:0] r_cnt;
    logic [31:0]       r_rem;
    logic [31:0]       r_dvs;
    logic [DIV_NW-1:0] r_quo;
    logic [32:0]       w_trial;
    logic              w_ge;
    logic              w_last;

    // one restoring step
    assign w_trial    = {r_rem, r_quo[DIV_NW-1]};
    assign w_ge       = (w_trial >= {1'b0, r_dvs});
    assign w_last     = (r_cnt == DIV_CW'(DIV_NW - 1));
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= !i_start && r_busy && w_last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? 32'(w_trial - {1'b0, r_dvs}) : w_trial[31:0];
            r_quo <= {r_quo[DIV_NW-2:0], w_ge};
        end
    end
endmodule
`default_nettype wire

// ===== design/ctr_back.sv =====
// ----------------------------------------------------------------------------
// ctr_back
// Executes queued items: table writes, temperature, search, interpolation,
// scaling and saturation.
// ----------------------------------------------------------------------------
`default_nettype none
module ctr_back #(
    parameter int TABLE_DEPTH = 4096
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  ctr_pkg::t_cfg       i_cfg,
    input  ctr_pkg::t_item      i_head,
    input  wire logic           i_head_vld,
    output logic                o_pop,
    output logic                o_done,
    output logic signed [63:0]  o_cooling_rate,
    output logic [1:0]          o_status
);
    import ctr_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_MUL_T  = 5'd1;
    localparam logic [4:0] S_DIV_T  = 5'd2;
    localparam logic [4:0] S_WAIT_T = 5'd3;
    localparam logic [4:0] S_MIN    = 5'd4;
    localparam logic [4:0] S_RD_HI  = 5'd5;
    localparam logic [4:0] S_RANGE  = 5'd6;
    localparam logic [4:0] S_SRCH   = 5'd7;
    localparam logic [4:0] S_SCMP   = 5'd8;
    localparam logic [4:0] S_FINAL  = 5'd9;
    localparam logic [4:0] S_MUL_Y  = 5'd10;
    localparam logic [4:0] S_DIV_I  = 5'd11;
    localparam logic [4:0] S_WAIT_I = 5'd12;
    localparam logic [4:0] S_MUL_A  = 5'd13;
    localparam logic [4:0] S_MUL_B  = 5'd14;
    localparam logic [4:0] S_PP0    = 5'd15;
    localparam logic [4:0] S_PP_MUL = 5'd16;
    localparam logic [4:0] S_PP_ADD = 5'd17;
    localparam logic [4:0] S_OUT    = 5'd18;

    logic [4:0]    r_state, n_state;
    t_item         r_item;
    logic [63:0]   r_t;
    logic [AW-1:0] r_klo, r_khi, r_mid;
    logic [31:0]   r_tlo, r_thi, r_llo, r_lhi, r_ri;
    logic [63:0]   r_x, r_prod, r_a, r_b;
    logic [127:0]  r_acc;
    logic [1:0]    r_pp;

    logic [31:0]       w_mul_a, w_mul_b;
    logic              w_div_start, w_div_done;
    logic [DIV_NW-1:0] w_dividend, w_quo;
    logic [31:0]       w_divisor;
    logic              w_we;
    logic [AW-1:0]     w_waddr, w_raddr, w_mid, w_khi0;
    logic [63:0]       w_rdata;
    logic [31:0]       w_rd_t, w_rd_l;
    logic [31:0]       w_idx32, w_ec32, w_n32;
    logic              w_adjacent;
    logic [63:0]       w_mag, w_m;
    logic [127:0]      w_pp_sh;

    assign w_rd_t = w_rdata[63:32];
    assign w_rd_l = w_rdata[31:0];

    // table write decode; indexes past the depth are dropped
    assign w_idx32 = 32'(i_head.idx);
    assign w_waddr = w_idx32[AW-1:0];
    assign o_pop   = (r_state == S_IDLE) && i_head_vld;
    assign w_we    = o_pop && (i_head.kind == KIND_WRITE)
                     && (w_idx32 < 32'(TABLE_DEPTH));

    // entries in use, clamped to [2, depth]
    always_comb begin
        w_ec32 = 32'(i_cfg.ecount);
        if (w_ec32 < 32'd2) begin
            w_n32 = 32'd2;
        end else if (w_ec32 > 32'(TABLE_DEPTH)) begin
            w_n32 = 32'(TABLE_DEPTH);
        end else begin
            w_n32 = w_ec32;
        end
    end
    assign w_khi0     = AW'(w_n32 - 32'd1);
    assign w_mid      = AW'(({1'b0, r_klo} + {1'b0, r_khi}) >> 1);
    assign w_adjacent = (({1'b0, r_klo} + 1'b1) == {1'b0, r_khi});

    // read address
    always_comb begin
        case (r_state)
            S_RD_HI: w_raddr = r_khi;
            S_SRCH:  w_raddr = w_mid;
            default: w_raddr = '0;
        endcase
    end

    ctr_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata ({i_head.etemp, i_head.erate}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // shared 32x32 multiplier operands
    always_comb begin
        case (r_state)
            S_MUL_T:  begin w_mul_a = r_item.pres;  w_mul_b = i_cfg.tfac;          end
            S_FINAL:  begin w_mul_a = r_llo;        w_mul_b = r_thi - r_t[31:0];   end
            S_MUL_Y:  begin w_mul_a = r_lhi;        w_mul_b = r_t[31:0] - r_tlo;   end
            S_MUL_A:  begin w_mul_a = i_cfg.rscale; w_mul_b = r_ri;                end
            S_MUL_B:  begin w_mul_a = r_item.dens;  w_mul_b = r_item.dens;         end
            S_PP_MUL: begin
                w_mul_a = r_pp[0] ? r_a[63:32] : r_a[31:0];
                w_mul_b = r_pp[1] ? r_b[63:32] : r_b[31:0];
            end
            default:  begin w_mul_a = '0;           w_mul_b = '0;                  end
        endcase
    end

    // divider operands
    assign w_div_start = (r_state == S_DIV_T) || (r_state == S_DIV_I);
    assign w_dividend  = (r_state == S_DIV_T) ? {1'b0, r_prod}
                                              : ({1'b0, r_x} + {1'b0, r_prod});
    assign w_divisor   = (r_state == S_DIV_T) ? r_item.dens : (r_thi - r_tlo);

    ctr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // partial product alignment
    always_comb begin
        case (r_pp)
            2'd0:    w_pp_sh = {64'd0, r_prod};
            2'd3:    w_pp_sh = {r_prod, 64'd0};
            default: w_pp_sh = {32'd0, r_prod, 32'd0};
        endcase
    end

    // magnitude with saturation at 2^63
    always_comb begin
        w_m = r_acc[111:48];
        if (r_acc[127:112] != 16'd0) begin
            w_mag = 64'h8000_0000_0000_0000;
        end else if (w_m > 64'h8000_0000_0000_0000) begin
            w_mag = 64'h8000_0000_0000_0000;
        end else begin
            w_mag = w_m;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_head_vld && i_head.kind == KIND_EVAL) n_state = S_MUL_T;
            S_MUL_T:  n_state = S_DIV_T;
            S_DIV_T:  n_state = S_WAIT_T;
            S_WAIT_T: if (w_div_done) n_state = S_MIN;
            S_MIN:    n_state = (r_t < 64'(i_cfg.tmin)) ? S_IDLE : S_RD_HI;
            S_RD_HI:  n_state = S_RANGE;
            S_RANGE:  n_state = (r_t > 64'(w_rd_t) || r_t < 64'(r_tlo)) ? S_IDLE : S_SRCH;
            S_SRCH:   n_state = w_adjacent ? S_FINAL : S_SCMP;
            S_SCMP:   n_state = S_SRCH;
            S_FINAL:  n_state = (r_thi <= r_tlo || r_t < 64'(r_tlo) || r_t > 64'(r_thi))
                                ? S_IDLE : S_MUL_Y;
            S_MUL_Y:  n_state = S_DIV_I;
            S_DIV_I:  n_state = S_WAIT_I;
            S_WAIT_I: if (w_div_done) n_state = S_MUL_A;
            S_MUL_A:  n_state = S_MUL_B;
            S_MUL_B:  n_state = S_PP0;
            S_PP0:    n_state = S_PP_MUL;
            S_PP_MUL: n_state = S_PP_ADD;
            S_PP_ADD: n_state = (r_pp == 2'd3) ? S_OUT : S_PP_MUL;
            S_OUT:    n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // control and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE:  o_done <= i_head_vld && (i_head.kind != KIND_EVAL);
                S_MIN:   o_done <= (r_t < 64'(i_cfg.tmin));
                S_RANGE: o_done <= (r_t > 64'(w_rd_t) || r_t < 64'(r_tlo));
                S_FINAL: o_done <= (r_thi <= r_tlo || r_t < 64'(r_tlo)
                                    || r_t > 64'(r_thi));
                S_OUT:   o_done <= 1'b1;
                default: o_done <= 1'b0;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(w_mul_a) * 64'(w_mul_b);
        case (r_state)
            S_IDLE: begin
                r_item         <= i_head;
                o_cooling_rate <= '0;
                o_status       <= (i_head.kind == KIND_ZDENS) ? ST_ZDENS : ST_OK;
            end
            S_WAIT_T: r_t <= w_quo[63:0];
            S_MIN: begin
                r_klo          <= '0;
                r_khi          <= w_khi0;
                o_cooling_rate <= '0;
                o_status       <= ST_BELOW;
            end
            S_RD_HI: begin
                r_tlo <= w_rd_t;
                r_llo <= w_rd_l;
            end
            S_RANGE: begin
                r_thi          <= w_rd_t;
                r_lhi          <= w_rd_l;
                o_cooling_rate <= '0;
                o_status       <= ST_RANGE;
            end
            S_SRCH: r_mid <= w_mid;
            S_SCMP: begin
                if (r_t <= 64'(w_rd_t)) begin
                    r_khi <= r_mid;
                    r_thi <= w_rd_t;
                    r_lhi <= w_rd_l;
                end else begin
                    r_klo <= r_mid;
                    r_tlo <= w_rd_t;
                    r_llo <= w_rd_l;
                end
            end
            S_FINAL: begin
                o_cooling_rate <= '0;
                o_status       <= ST_RANGE;
            end
            S_MUL_Y:  r_x  <= r_prod;
            S_WAIT_I: r_ri <= w_quo[31:0];
            S_MUL_B:  r_a  <= r_prod;
            S_PP0: begin
                r_b   <= r_prod;
                r_acc <= '0;
                r_pp  <= 2'd0;
            end
            S_PP_ADD: begin
                r_acc <= r_acc + w_pp_sh;
                r_pp  <= r_pp + 2'd1;
            end
            S_OUT: begin
                o_cooling_rate <= 64'd0 - w_mag;
                o_status       <= ST_OK;
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// ===== design/tabulated_cooling_rate_unit.sv =====
// ----------------------------------------------------------------------------
// tabulated_cooling_rate_unit
// Cooling rate from a loaded temperature table with linear interpolation.
// ----------------------------------------------------------------------------
//  channel   | handshake               | payload
//  ----------+-------------------------+------------------------------------
//  command   | start / busy            | command, entry_*, density, pressure
//  result    | o_done (one cycle)      | cooling_rate, status
//  config    | i_cfg_we                | i_cfg_idx, i_cfg_data
//
//  A table write or zero density result is registered once the idle back
//  part pops the item from the queue. A full evaluation runs k search steps,
//  at most ceil(log2(entry_count - 1)); two bit-serial divisions dominate,
//  and each search step costs a table read and a compare.
//  busy rises when the two entry command queue is full.
//  Synchronous active-low reset clears control; the table is not cleared.
//  Results cannot be stalled; o_done is high for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module tabulated_cooling_rate_unit #(
    parameter int TABLE_DEPTH = 4096
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_command,
    input  wire logic [11:0]        i_entry_index,
    input  wire logic [31:0]        i_entry_temperature,
    input  wire logic [31:0]        i_entry_rate,
    input  wire logic [31:0]        i_density,
    input  wire logic signed [31:0] i_pressure,
    output logic                    o_done,
    output logic signed [63:0]      o_cooling_rate,
    output logic [1:0]              o_status,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [31:0]        i_cfg_data
);
    import ctr_pkg::*;

    t_cfg  r_cfg;
    t_item w_head;
    logic  w_head_vld, w_pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tfac   <= 32'd256;
            r_cfg.tmin   <= 32'd0;
            r_cfg.pfloor <= 31'd1;
            r_cfg.rscale <= 32'd0;
            r_cfg.ecount <= 13'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TFAC:   r_cfg.tfac   <= i_cfg_data;
                CFG_TMIN:   r_cfg.tmin   <= i_cfg_data;
                CFG_PFLOOR: r_cfg.pfloor <= i_cfg_data[30:0];
                CFG_RSCALE: r_cfg.rscale <= i_cfg_data;
                CFG_ECOUNT: r_cfg.ecount <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    ctr_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_command           (i_command),
        .i_entry_index       (i_entry_index),
        .i_entry_temperature (i_entry_temperature),
        .i_entry_rate        (i_entry_rate),
        .i_density           (i_density),
        .i_pressure          (i_pressure),
        .i_pfloor            (r_cfg.pfloor),
        .o_head              (w_head),
        .o_head_vld          (w_head_vld),
        .i_pop               (w_pop)
    );

    ctr_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_head         (w_head),
        .i_head_vld     (w_head_vld),
        .o_pop          (w_pop),
        .o_done         (o_done),
        .o_cooling_rate (o_cooling_rate),
        .o_status       (o_status)
    );
endmodule
`default_nettype wire

// ===== design/ctr_chk.sv =====
// ----------------------------------------------------------------------------
// ctr_chk
// Port level checks for the tabulated cooling rate unit.
// ----------------------------------------------------------------------------
`default_nettype none
`include "tabulated_cooling_rate_unit_defines.svh"
module ctr_chk (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               busy,
    input wire logic               o_done,
    input wire logic signed [63:0] o_cooling_rate,
    input wire logic [1:0]         o_status
);
    import ctr_pkg::*;

    logic w_rate_ok, w_err, w_zero;

    assign w_zero    = (o_cooling_rate == 64'sd0);
    assign w_rate_ok = o_cooling_rate[63] || w_zero;
    assign w_err     = (o_status != ST_OK);

    // cooling never adds energy
    `CTR_ASSERT(a_rate_nonpos, i_clk, i_rst_n, o_done |-> w_rate_ok, "positive cooling rate")

    // any error status carries a zero rate
    `CTR_ASSERT(a_err_zero, i_clk, i_rst_n, (o_done && w_err) |-> w_zero, "rate with error")

    // queue is empty right after reset
    `CTR_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !busy, "busy after reset")
endmodule

bind tabulated_cooling_rate_unit ctr_chk u_chk (.*);
`default_nettype wire
